// ===== rtl/core/qmtf_pkg.sv =====
// Shared types and constants for the queue with move-to-front.
package qmtf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int KIND_W          = 2;
    localparam int STATUS_W        = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_MOVE   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NOTFOUND  = 2'd3
    } status_t;

    // Per-cycle command that every cell of the row sees.
    typedef struct packed {
        logic append;
        logic remove;
        logic move_ok;
    } cell_ctl_t;

endpackage

// ===== rtl/core/qmtf_cell.sv =====
// One slot of the queue: holds an entry, matches it, and shifts with its neighbors.
module qmtf_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                         clk,
    input  qmtf_pkg::cell_ctl_t          ctl,
    input  logic signed [qmtf_pkg::DATA_W-1:0] value,
    input  logic [CNT_W-1:0]             count,
    input  logic signed [qmtf_pkg::DATA_W-1:0] prev_data,
    input  logic signed [qmtf_pkg::DATA_W-1:0] next_data,
    input  logic                         found_in,
    output logic                         found_out,
    output logic signed [qmtf_pkg::DATA_W-1:0] data
);

    logic signed [qmtf_pkg::DATA_W-1:0] data_reg;
    logic signed [qmtf_pkg::DATA_W-1:0] data_next;
    logic                               in_range;
    logic                               is_tail;

    assign in_range  = (count > CNT_W'(IDX));
    assign is_tail   = (count == CNT_W'(IDX));
    assign found_out = found_in | (in_range && (data_reg == value));
    assign data      = data_reg;

    // A cell shifts back during a move only if no earlier cell holds the match.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.append && is_tail)
        begin
            data_next = value;
        end
        else if (ctl.remove)
        begin
            data_next = next_data;
        end
        else if (ctl.move_ok && !found_in)
        begin
            data_next = prev_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/core/queue_with_move_to_front.sv =====
// Bounded FIFO of signed words with append, remove-front and move-to-front.
//
// Usage: drive kind and value and raise start; a command word is taken at a
// rising edge where start is high and busy is low. No command has to wait,
// so busy stays low and a new command may be issued every cycle.
// Kind 0 appends value at the back, 1 removes the front, 2 finds the first
// entry equal to value and moves it to the front; kind 3 does nothing.
// The result word appears in the cycle after the command is taken, with
// done high for exactly that cycle: front_value (zero when empty),
// entry_total, is_empty and status (ok, overflow, underflow, not found).
// Throughput is one command per cycle; it is set by the row of cells, each of
// which compares its entry combinationally and shifts with its neighbors,
// with the match found by a ripple through the row.
// The receiver cannot stall; a result not sampled in its cycle is gone.
// Reset clears the entry count and the result strobe; slot contents are not
// cleared and are never shown before they are written.
module queue_with_move_to_front #(
    parameter int QUEUE_DEPTH = qmtf_pkg::QUEUE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [qmtf_pkg::KIND_W-1:0]        kind,
    input  logic signed [qmtf_pkg::DATA_W-1:0] value,
    output logic                               done,
    output logic signed [qmtf_pkg::DATA_W-1:0] front_value,
    output logic [CNT_W-1:0]                   entry_total,
    output logic                               is_empty,
    output logic [qmtf_pkg::STATUS_W-1:0]      status
);

    logic signed [qmtf_pkg::DATA_W-1:0] cell_data [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]               found_chain;
    logic                               found_any;
    logic                               accept;
    qmtf_pkg::cell_ctl_t                ctl;
    qmtf_pkg::kind_t                    kind_in;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    qmtf_pkg::status_t status_reg;
    qmtf_pkg::status_t status_next;

    // No command ever has to wait, so busy is tied low.
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign kind_in   = qmtf_pkg::kind_t'(kind);
    assign found_chain[0] = 1'b0;
    assign found_any = found_chain[QUEUE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic signed [qmtf_pkg::DATA_W-1:0] prev_d;
            logic signed [qmtf_pkg::DATA_W-1:0] next_d;

            if (gi == 0)
            begin : g_head
                assign prev_d = value;
            end
            else
            begin : g_body
                assign prev_d = cell_data[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_d = cell_data[gi];
            end
            else
            begin : g_mid
                assign next_d = cell_data[gi+1];
            end

            qmtf_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .value     (value),
                .count     (count_reg),
                .prev_data (prev_d),
                .next_data (next_d),
                .found_in  (found_chain[gi]),
                .found_out (found_chain[gi+1]),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ctl         = '0;
        count_next  = count_reg;
        status_next = qmtf_pkg::ST_OK;
        if (accept)
        begin
            case (kind_in)
                qmtf_pkg::KIND_APPEND:
                begin
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        status_next = qmtf_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        ctl.append = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                qmtf_pkg::KIND_REMOVE:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = qmtf_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.remove = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                qmtf_pkg::KIND_MOVE:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = qmtf_pkg::ST_UNDERFLOW;
                    end
                    else if (!found_any)
                    begin
                        status_next = qmtf_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        ctl.move_ok = 1'b1;
                    end
                end
                default:
                begin
                    status_next = qmtf_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= qmtf_pkg::ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    // The result is read straight from the state the command just left.
    assign done        = done_reg;
    assign entry_total = count_reg;
    assign is_empty    = (count_reg == '0);
    assign front_value = (count_reg != '0) ? cell_data[0] : '0;
    assign status      = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == qmtf_pkg::ST_OVERFLOW) |-> count_reg == CNT_W'(QUEUE_DEPTH))
        else $error("overflow reported on a queue that is not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == qmtf_pkg::ST_UNDERFLOW) |-> is_empty)
        else $error("underflow reported on a queue that is not empty");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == qmtf_pkg::KIND_APPEND && count_reg != CNT_W'(QUEUE_DEPTH))
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the queue");

    a_move_front: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == qmtf_pkg::KIND_MOVE)
        |=> (status != qmtf_pkg::ST_OK || front_value == $past(value)))
        else $error("moved word is not at the front");

endmodule

// ===== sim/queue_with_move_to_front_checker.sv =====
// Checker for the move-to-front queue: mirrors the queue and compares every result word.
`timescale 1ns / 100ps

module queue_with_move_to_front_checker
    import qmtf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     done,
    input  logic signed [DATA_W-1:0] front_value,
    input  logic [CNT_W-1:0]         entry_total,
    input  logic                     is_empty,
    input  logic [STATUS_W-1:0]      status,
    output int                       mismatch_count,
    output int                       waiting_words
);

    typedef struct packed {
        logic signed [DATA_W-1:0] front;
        logic [CNT_W-1:0]         total;
        logic                     empty;
        status_t                  code;
    } queue_report_t;

    // Shadow copy of the queue; slot 0 is the front.
    logic signed [DATA_W-1:0] shadow_slots [QUEUE_DEPTH];
    int                       shadow_held;
    queue_report_t            reports_due [$];

    initial
    begin
        mismatch_count = 0;
        waiting_words  = 0;
        shadow_held    = 0;
    end

    task automatic apply_command(input kind_t op, input logic signed [DATA_W-1:0] v,
                                 output queue_report_t rep);
        int i;
        int hit;
        rep.code = ST_OK;
        case (op)
            KIND_APPEND:
                if (shadow_held == QUEUE_DEPTH)
                    rep.code = ST_OVERFLOW;
                else
                begin
                    shadow_slots[shadow_held] = v;
                    shadow_held++;
                end
            KIND_REMOVE:
                if (shadow_held == 0)
                    rep.code = ST_UNDERFLOW;
                else
                begin
                    for (i = 1; i < shadow_held; i++)
                        shadow_slots[i-1] = shadow_slots[i];
                    shadow_held--;
                end
            KIND_MOVE:
                if (shadow_held == 0)
                    rep.code = ST_UNDERFLOW;
                else
                begin
                    // Only the match nearest the front moves; the entries ahead of it slide back by one.
                    hit = -1;
                    for (i = 0; i < shadow_held; i++)
                        if (hit < 0 && shadow_slots[i] == v)
                            hit = i;
                    if (hit < 0)
                        rep.code = ST_NOTFOUND;
                    else
                    begin
                        for (i = hit; i > 0; i--)
                            shadow_slots[i] = shadow_slots[i-1];
                        shadow_slots[0] = v;
                    end
                end
            default:
                ;
        endcase
        rep.front = (shadow_held != 0) ? shadow_slots[0] : '0;
        rep.total = CNT_W'(shadow_held);
        rep.empty = (shadow_held == 0);
    endtask

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        queue_report_t rep;
        if (rst_n)
        begin
            if (done)
            begin
                if (reports_due.size() == 0)
                begin
                    $display("%0t: result word with no command pending, front %0d count %0d",
                             $time, front_value, entry_total);
                    mismatch_count++;
                end
                else
                begin
                    rep = reports_due.pop_front();
                    check_field("front_value", rep.front, front_value);
                    check_field("entry_total", rep.total, entry_total);
                    check_field("is_empty", rep.empty, is_empty);
                    check_field("status", rep.code, status);
                end
            end
            if (start && !busy)
            begin
                apply_command(kind_t'(kind), value, rep);
                reports_due.push_back(rep);
            end
            waiting_words = reports_due.size();
        end
    end

endmodule

// ===== sim/queue_with_move_to_front_tb.sv =====
// Testbench top for the move-to-front queue: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module queue_with_move_to_front_tb;
    import qmtf_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int RANDOM_CMDS = 1200;
    localparam int CYCLE_LIMIT = 200000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic signed [DATA_W-1:0] front_value;
    logic [CNT_W-1:0]         entry_total;
    logic                     is_empty;
    logic [STATUS_W-1:0]      status;
    int                       mismatch_count;
    int                       waiting_words;
    int                       cycle_count;

    // Small set of values so that moves usually hit and duplicates show up.
    logic signed [DATA_W-1:0] value_pool [8];

    queue_with_move_to_front #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .value       (value),
        .done        (done),
        .front_value (front_value),
        .entry_total (entry_total),
        .is_empty    (is_empty),
        .status      (status)
    );

    queue_with_move_to_front_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .value          (value),
        .done           (done),
        .front_value    (front_value),
        .entry_total    (entry_total),
        .is_empty       (is_empty),
        .status         (status),
        .mismatch_count (mismatch_count),
        .waiting_words  (waiting_words)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input kind_t op, input logic signed [DATA_W-1:0] v);
        int roll;
        int gap;
        start <= 1'b1;
        kind  <= op;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        roll = $urandom_range(0, 99);
        if (roll < 55)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap != 0)
        begin
            // Junk on the command lines while start is low must be ignored.
            start <= 1'b0;
            kind  <= KIND_W'($urandom);
            value <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (waiting_words != 0);
        @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    initial
    begin
        int n;
        int append_pct;
        kind_t op;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        kind  = KIND_NONE;
        value = '0;
        value_pool[0] = 32'sh7fffffff;
        value_pool[1] = 32'sh80000000;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (n = 4; n < 8; n++)
            value_pool[n] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: remove and move both underflow, the spare kind does nothing.
        send_word(KIND_REMOVE, '0);
        send_word(KIND_MOVE, 32'sh7fffffff);
        send_word(KIND_NONE, -32'sd1);
        send_word(KIND_APPEND, 32'sh7fffffff);
        send_word(KIND_APPEND, 32'sh80000000);
        send_word(KIND_APPEND, '0);
        send_word(KIND_APPEND, -32'sd1);
        send_word(KIND_APPEND, 32'sh80000000);
        // The first of the two minimum values moves; -1 then moves twice, the second time as the front itself.
        send_word(KIND_MOVE, 32'sh80000000);
        send_word(KIND_MOVE, -32'sd1);
        send_word(KIND_MOVE, -32'sd1);
        send_word(KIND_MOVE, 32'sd77);
        // Fill to the top, then one append that must be dropped.
        for (n = 0; n < DEPTH - 5; n++)
            send_word(KIND_APPEND, (n % 2) ? 32'sh55555555 : 32'shaaaaaaaa);
        send_word(KIND_APPEND, 32'sd1);
        send_word(KIND_NONE, '0);
        wait_drained();

        append_pct = 50;
        for (n = 0; n < RANDOM_CMDS; n++)
        begin
            // Phases lean toward filling, draining or holding level.
            if (n % 60 == 0)
                append_pct = 25 + 25 * $urandom_range(0, 2);
            if (n == 400 || n == 900)
                wait_drained();
            if ($urandom_range(0, 99) < 3)
                op = KIND_NONE;
            else if ($urandom_range(0, 99) < append_pct)
                op = KIND_APPEND;
            else if ($urandom_range(0, 1) == 0)
                op = KIND_REMOVE;
            else
                op = KIND_MOVE;
            send_word(op, pick_value());
        end

        wait_drained();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && waiting_words == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/qmtf_pkg.sv
rtl/core/qmtf_cell.sv
rtl/core/queue_with_move_to_front.sv
sim/queue_with_move_to_front_checker.sv
sim/queue_with_move_to_front_tb.sv
